>>> design/kswt_pkg.sv
// ----------------------------------------------------------------------------
// Knob switch mode value tracker package
// Shared constants, register codes and types for the knob value tracker.
// ----------------------------------------------------------------------------
package kswt_pkg;

	localparam int BANKS  = 4;
	localparam int KNOBS  = 16;
	localparam int ROWS   = BANKS * KNOBS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int BANK_W = 2;
	localparam int KNOB_W = 4;
	localparam int VAL_W  = 16;
	localparam int ADDR_W = 5;

	localparam logic [VAL_W-1:0] RST_VALUE_MIN       = 16'd0;
	localparam logic [VAL_W-1:0] RST_VALUE_MAX       = 16'd16383;
	localparam logic [VAL_W-1:0] RST_STEP_SIZE       = 16'd1000;
	localparam logic [VAL_W-1:0] RST_SECONDARY_START = 16'd8192;

	localparam logic [1:0] DIR_CW  = 2'd1;
	localparam logic [1:0] DIR_CCW = 2'd2;

	typedef enum logic [2:0] {
		MODE_OFF           = 3'd0,
		MODE_MIDI          = 3'd1,
		MODE_RESET_PRESS   = 3'd2,
		MODE_RESET_RELEASE = 3'd3,
		MODE_FINE_HOLD     = 3'd4,
		MODE_FINE_TOGGLE   = 3'd5,
		MODE_ALT_HOLD      = 3'd6,
		MODE_ALT_TOGGLE    = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		REG_SWITCH_MODE     = 3'd0,
		REG_VALUE_MIN       = 3'd1,
		REG_VALUE_MAX       = 3'd2,
		REG_STEP_SIZE       = 3'd3,
		REG_SECONDARY_START = 3'd4,
		REG_PRIMARY_SEND    = 3'd5,
		REG_SECONDARY_SEND  = 3'd6,
		REG_UNUSED          = 3'd7
	} reg_idx_t;

	typedef struct packed {
		mode_t             switch_mode;
		logic [VAL_W-1:0]  value_min;
		logic [VAL_W-1:0]  value_max;
		logic [VAL_W-1:0]  step_size;
		logic [VAL_W-1:0]  secondary_start;
		logic              primary_send_enable;
		logic              secondary_send_enable;
	} cfg_t;

	typedef struct packed {
		logic [VAL_W-1:0] primary_value;
		logic [VAL_W-1:0] secondary_value;
		logic             primary_selected;
		logic             primary_fine;
		logic             secondary_fine;
		logic             held_level;
		logic             primary_redraw;
		logic             secondary_redraw;
	} row_t;

	localparam int ROW_BITS = $bits(row_t);

	localparam row_t ROW_RESET = '{
		primary_value:    RST_VALUE_MIN,
		secondary_value:  RST_SECONDARY_START,
		primary_selected: 1'b1,
		primary_fine:     1'b0,
		secondary_fine:   1'b1,
		held_level:       1'b0,
		primary_redraw:   1'b1,
		secondary_redraw: 1'b1
	};

	typedef struct packed {
		logic [1:0] direction;
		logic       level;
		logic       pressed;
		logic       released;
	} evt_t;

	typedef struct packed {
		logic [VAL_W-1:0] active_value;
		logic             primary_active;
		logic             fine_adjust;
		logic             send_value;
		logic             display_invalid;
	} res_t;

endpackage

>>> design/kswt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module kswt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/kswt_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the global knob settings.
// ----------------------------------------------------------------------------
module kswt_regs
	import kswt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.switch_mode           <= MODE_ALT_TOGGLE;
			cfg_q.value_min             <= RST_VALUE_MIN;
			cfg_q.value_max             <= RST_VALUE_MAX;
			cfg_q.step_size             <= RST_STEP_SIZE;
			cfg_q.secondary_start       <= RST_SECONDARY_START;
			cfg_q.primary_send_enable   <= 1'b1;
			cfg_q.secondary_send_enable <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				REG_SWITCH_MODE:     cfg_q.switch_mode <= mode_t'(pwdata[2:0]);
				REG_VALUE_MIN:       cfg_q.value_min <= pwdata[VAL_W-1:0];
				REG_VALUE_MAX:       cfg_q.value_max <= pwdata[VAL_W-1:0];
				REG_STEP_SIZE:       cfg_q.step_size <= pwdata[VAL_W-1:0];
				REG_SECONDARY_START: cfg_q.secondary_start <= pwdata[VAL_W-1:0];
				REG_PRIMARY_SEND:    cfg_q.primary_send_enable <= pwdata[0];
				REG_SECONDARY_SEND:  cfg_q.secondary_send_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SWITCH_MODE:     prdata = {29'd0, cfg_q.switch_mode};
			REG_VALUE_MIN:       prdata = {16'd0, cfg_q.value_min};
			REG_VALUE_MAX:       prdata = {16'd0, cfg_q.value_max};
			REG_STEP_SIZE:       prdata = {16'd0, cfg_q.step_size};
			REG_SECONDARY_START: prdata = {16'd0, cfg_q.secondary_start};
			REG_PRIMARY_SEND:    prdata = {31'd0, cfg_q.primary_send_enable};
			REG_SECONDARY_SEND:  prdata = {31'd0, cfg_q.secondary_send_enable};
			default:             prdata = '0;
		endcase
	end

endmodule

>>> design/kswt_update.sv
// ----------------------------------------------------------------------------
// Knob row update
// Applies the switch mode and one rotation step to one knob state row.
// ----------------------------------------------------------------------------
module kswt_update
	import kswt_pkg::*;
(
	input  cfg_t cfg,
	input  row_t cur,
	input  evt_t evt,
	output row_t nxt,
	output res_t res
);

	logic               redraw;
	logic               send;
	logic               prim;
	logic               enabled;
	logic [VAL_W-1:0]   val;
	logic [VAL_W-1:0]   sat;
	logic signed [17:0] sum;
	logic signed [17:0] lim_max;
	logic signed [17:0] lim_min;

	always_comb begin
		nxt    = cur;
		redraw = 1'b0;
		send   = 1'b0;

		if (cfg.switch_mode != MODE_OFF) begin
			nxt.held_level = evt.level;
		end

		unique case (cfg.switch_mode)
			MODE_RESET_PRESS, MODE_RESET_RELEASE: begin
				if ((cfg.switch_mode == MODE_RESET_PRESS && evt.pressed) ||
				    (cfg.switch_mode == MODE_RESET_RELEASE && evt.released)) begin
					if (cur.primary_selected) begin
						nxt.primary_value = cfg.value_min;
					end else begin
						nxt.secondary_value = cfg.value_min;
					end
					redraw = 1'b1;
					send   = 1'b1;
				end
			end
			MODE_FINE_HOLD: begin
				if (cur.primary_selected) begin
					nxt.primary_fine   = evt.level;
					nxt.secondary_fine = 1'b0;
				end else begin
					nxt.secondary_fine = evt.level;
					nxt.primary_fine   = 1'b0;
				end
			end
			MODE_FINE_TOGGLE: begin
				if (evt.pressed) begin
					if (cur.primary_selected) begin
						nxt.primary_fine = ~cur.primary_fine;
					end else begin
						nxt.secondary_fine = ~cur.secondary_fine;
					end
				end
			end
			MODE_ALT_HOLD: begin
				if (~evt.level != cur.primary_selected) begin
					redraw = 1'b1;
				end
				nxt.primary_selected = ~evt.level;
			end
			MODE_ALT_TOGGLE: begin
				if (evt.pressed) begin
					nxt.primary_selected = ~cur.primary_selected;
					redraw               = 1'b1;
				end
			end
			default: ;
		endcase

		prim    = nxt.primary_selected;
		val     = prim ? nxt.primary_value : nxt.secondary_value;
		enabled = prim ? cfg.primary_send_enable : cfg.secondary_send_enable;

		lim_max = $signed({2'b00, cfg.value_max});
		lim_min = $signed({2'b00, cfg.value_min});
		if (evt.direction == DIR_CW) begin
			sum = $signed({2'b00, val}) + $signed({2'b00, cfg.step_size});
		end else begin
			sum = $signed({2'b00, val}) - $signed({2'b00, cfg.step_size});
		end
		if (sum >= lim_max) begin
			sat = cfg.value_max;
		end else if (sum < lim_min) begin
			sat = cfg.value_min;
		end else begin
			sat = sum[VAL_W-1:0];
		end

		if (enabled) begin
			if (evt.direction == DIR_CW || evt.direction == DIR_CCW) begin
				if (sat != val) begin
					send   = 1'b1;
					redraw = 1'b1;
				end
				val = sat;
				if (prim) begin
					nxt.primary_value = sat;
				end else begin
					nxt.secondary_value = sat;
				end
			end
			if (prim) begin
				nxt.primary_redraw = redraw;
			end else begin
				nxt.secondary_redraw = redraw;
			end
		end else begin
			send = 1'b0;
		end

		res.active_value    = val;
		res.primary_active  = prim;
		res.fine_adjust     = prim ? nxt.primary_fine : nxt.secondary_fine;
		res.send_value      = send;
		res.display_invalid = prim ? nxt.primary_redraw : nxt.secondary_redraw;
	end

endmodule

>>> design/knob_switch_mode_value_tracker.sv
// ----------------------------------------------------------------------------
// Knob switch mode value tracker
// Tracks primary and secondary values per knob and bank under push-switch modes.
// ----------------------------------------------------------------------------
// Pipeline: an accepted start is registered into the update stage, and the result
// strobe and result fields are registered from that stage.
// Throughput: one transaction per cycle; busy stays low, as the row table is
// read one cycle and written the next with a bypass for back-to-back rows.
// Reset: arst_n clears control state and all row valid bits, so every row reads
// its reset contents until first written. The receiver cannot stall results.
module knob_switch_mode_value_tracker
	import kswt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [BANK_W-1:0] bank,
	input  logic [KNOB_W-1:0] knob,
	input  logic [1:0]        direction,
	input  logic              switch_level,
	input  logic              switch_pressed,
	input  logic              switch_released,
	output logic              result_valid,
	output logic [VAL_W-1:0]  active_value,
	output logic              primary_active,
	output logic              fine_adjust,
	output logic              send_value,
	output logic              display_invalid,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t                cfg;
	logic                accept;
	logic                in_range;
	logic [ROW_W-1:0]    row_in;
	logic                valid_s1;
	logic                range_s1;
	logic                fwd_s1;
	logic [ROW_W-1:0]    row_s1;
	evt_t                evt_s1;
	logic [ROWS-1:0]     vld_q;
	row_t                byp_q;
	logic [ROW_BITS-1:0] rd_data;
	row_t                cur;
	row_t                nxt;
	res_t                res;
	logic                ram_we;
	logic                result_valid_q;
	res_t                res_q;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;

	assign in_range = (32'(bank) < BANKS) && (32'(knob) < KNOBS);
	assign row_in   = ROW_W'(32'(bank) * KNOBS + (KNOBS - 1 - 32'(knob)));

	kswt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	kswt_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_s1),
		.wdata (nxt),
		.raddr (row_in),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			fwd_s1   <= accept && ram_we && (row_s1 == row_in);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1             <= row_in;
			range_s1           <= in_range;
			evt_s1.direction   <= direction;
			evt_s1.level       <= switch_level;
			evt_s1.pressed     <= switch_pressed;
			evt_s1.released    <= switch_released;
		end
		if (ram_we) begin
			byp_q <= nxt;
		end
	end

	assign cur = fwd_s1 ? byp_q : (vld_q[row_s1] ? row_t'(rd_data) : ROW_RESET);

	kswt_update u_update (
		.cfg (cfg),
		.cur (cur),
		.evt (evt_s1),
		.nxt (nxt),
		.res (res)
	);

	assign ram_we = valid_s1 && range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
			if (ram_we) begin
				vld_q[row_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= range_s1 ? res : '0;
		end
	end

	assign result_valid    = result_valid_q;
	assign active_value    = res_q.active_value;
	assign primary_active  = res_q.primary_active;
	assign fine_adjust     = res_q.fine_adjust;
	assign send_value      = res_q.send_value;
	assign display_invalid = res_q.display_invalid;

`ifndef NO_ASSERTIONS
	a_start_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transaction did not reach the update stage");

	a_s1_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> result_valid)
		else $error("update stage did not produce a result");

	a_fwd_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1 && $past(ram_we))
		else $error("bypass selected without a preceding row write");

	a_send_implies_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && send_value |-> display_invalid)
		else $error("value sent without the display being marked for redraw");
`endif

endmodule
